// ===== rtl/bpa_pkg.sv =====
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types and codes for the buddy page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

  // Order fields are wide enough for every supported top order (up to 10)
  localparam int unsigned ORD_W = 4;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;
  localparam logic STAT_OK    = 1'b0;
  localparam logic STAT_FAIL  = 1'b1;

  localparam logic [10:0] FREE_SAT = 11'd2047;

  // Input beat
  typedef struct packed {
    logic        kind;
    logic [10:0] page_count;
    logic [9:0]  base_page;
  } in_t;

  // Result beat
  typedef struct packed {
    logic        status;
    logic [9:0]  block_page;
    logic [10:0] free_total;
  } out_t;

  // Command classes produced by the front end
  typedef enum logic [1:0] {
    CMD_ALLOC,
    CMD_FREE,
    CMD_FAIL,
    CMD_SKIP
  } cmd_e;

  typedef struct packed {
    cmd_e             cls;
    logic [ORD_W-1:0] ord;
    logic [10:0]      page_count;
    logic [9:0]       base_page;
  } cmd_t;

  // One page entry of the block table
  typedef struct packed {
    logic             head;
    logic [ORD_W-1:0] ord;
  } ent_t;

  // Back end sequencer states
  typedef enum logic [3:0] {
    B_CINIT,
    B_CARVE,
    B_IDLE,
    B_SRCH,
    B_SPL,
    B_SPL_WR,
    B_FRD,
    B_FWR,
    B_BRD,
    B_BCHK,
    B_PUT,
    B_DONE
  } bst_e;

endpackage

// ===== rtl/buddy_page_allocator.sv =====
// ----------------------------------------------------------------------------
// buddy_page_allocator
// Buddy allocator over pages 0..min(managed_pages, NUM_PAGES)-1, block orders 0..TOP_ORDER.
//
//   channel   dir   handshake                  beat
//   request   in    push / full                in_item_i  (in_t)
//   result    out   empty / pop                out_item_o (out_t)
//   config    in    cfg_we_i, no wait          cfg_wdata_i (managed_pages)
//
// Free: clears the freed page's entry, merges with each buddy that is a free head
// of the same order, then writes the head. Allocate: scans the block table (one
// block table read per cycle) and splits down to the wanted order; a failing,
// zero or skipped request goes straight to the result. After reset and after
// each cfg write the block table is re-carved; requests queue up (two deep) but
// are not executed. Request and result queues let each side stall independently.
// ----------------------------------------------------------------------------
module buddy_page_allocator
  import bpa_pkg::*;
#(
  parameter int unsigned NUM_PAGES = 1024,
  parameter int unsigned TOP_ORDER = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  input  in_t         in_item_i,
  output logic        full,
  output logic        empty,
  input  logic        pop,
  output out_t        out_item_o,
  input  logic        cfg_we_i,
  input  logic [10:0] cfg_wdata_i
);

  localparam int unsigned RW = $clog2(NUM_PAGES + 1);

  logic          cmd_valid, cmd_pop, res_push, res_full;
  cmd_t          cmd;
  out_t          res_item;
  logic [RW-1:0] region;
  logic [$bits(out_t)-1:0] res_rdata;

  bpa_front #(
    .TOP_ORDER(TOP_ORDER),
    .RW       (RW)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .in_item_i  (in_item_i),
    .full_o     (full),
    .region_i   (region),
    .cmd_valid_o(cmd_valid),
    .cmd_o      (cmd),
    .cmd_pop_i  (cmd_pop)
  );

  bpa_back #(
    .NUM_PAGES(NUM_PAGES),
    .TOP_ORDER(TOP_ORDER),
    .RW       (RW)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .region_o   (region),
    .cmd_valid_i(cmd_valid),
    .cmd_i      (cmd),
    .cmd_pop_o  (cmd_pop),
    .res_push_o (res_push),
    .res_item_o (res_item),
    .res_full_i (res_full)
  );

  // result queue
  bpa_fifo #(
    .WIDTH($bits(out_t)),
    .DEPTH(2)
  ) u_resq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .wdata_i(res_item),
    .full_o (res_full),
    .pop_i  (pop),
    .rdata_o(res_rdata),
    .empty_o(empty)
  );

  assign out_item_o = out_t'(res_rdata);

endmodule

// ===== rtl/bpa_ram.sv =====
// ----------------------------------------------------------------------------
// bpa_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bpa_ram #(
  parameter int unsigned WIDTH = 5,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/bpa_fifo.sv =====
// ----------------------------------------------------------------------------
// bpa_fifo
// Small register queue used between the stages.
// ----------------------------------------------------------------------------
module bpa_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wp_q, wp_d, rp_q, rp_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rp_q];

  // pointer and fill count update
  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wp_d = (32'(wp_q) == DEPTH - 1) ? '0 : wp_q + 1'b1;
    end
    if (do_pop) begin
      rp_d = (32'(rp_q) == DEPTH - 1) ? '0 : rp_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q] <= wdata_i;
    end
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= DEPTH)
    else $error("queue fill count beyond depth");

endmodule

// ===== rtl/bpa_front.sv =====
// ----------------------------------------------------------------------------
// bpa_front
// Accepts request beats, rounds the count to an order and classifies them.
// ----------------------------------------------------------------------------
module bpa_front
  import bpa_pkg::*;
#(
  parameter int unsigned TOP_ORDER = 4,
  parameter int unsigned RW        = 11
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  in_t           in_item_i,
  output logic          full_o,
  input  logic [RW-1:0] region_i,
  output logic          cmd_valid_o,
  output cmd_t          cmd_o,
  input  logic          cmd_pop_i
);

  logic [ORD_W-1:0] want;
  cmd_t             cmd;
  logic             q_empty;
  logic [$bits(cmd_t)-1:0] q_rdata;

  // smallest order that covers the page count, capped at the top order
  always_comb begin
    want = ORD_W'(TOP_ORDER);
    for (int o = TOP_ORDER; o >= 0; o--) begin
      if ((32'(1) << o) >= 32'(in_item_i.page_count)) begin
        want = ORD_W'(o);
      end
    end
  end

  // classify
  always_comb begin
    cmd.ord        = want;
    cmd.page_count = in_item_i.page_count;
    cmd.base_page  = in_item_i.base_page;
    if (in_item_i.kind == KIND_ALLOC) begin
      cmd.cls = (in_item_i.page_count == '0) ? CMD_FAIL : CMD_ALLOC;
    end else if (in_item_i.page_count == '0 ||
                 32'(in_item_i.base_page) >= 32'(region_i)) begin
      cmd.cls = CMD_SKIP;
    end else begin
      cmd.cls = CMD_FREE;
    end
  end

  bpa_fifo #(
    .WIDTH($bits(cmd_t)),
    .DEPTH(2)
  ) u_cmdq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push_i),
    .wdata_i(cmd),
    .full_o (full_o),
    .pop_i  (cmd_pop_i),
    .rdata_o(q_rdata),
    .empty_o(q_empty)
  );

  assign cmd_valid_o = !q_empty;
  assign cmd_o       = cmd_t'(q_rdata);

endmodule

// ===== rtl/bpa_back.sv =====
// ----------------------------------------------------------------------------
// bpa_back
// Block table, per-order counts and the split / merge sequencer.
// ----------------------------------------------------------------------------
module bpa_back
  import bpa_pkg::*;
#(
  parameter int unsigned NUM_PAGES = 1024,
  parameter int unsigned TOP_ORDER = 4,
  parameter int unsigned RW        = 11
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [10:0]   cfg_wdata_i,
  output logic [RW-1:0] region_o,
  input  logic          cmd_valid_i,
  input  cmd_t          cmd_i,
  output logic          cmd_pop_o,
  output logic          res_push_o,
  output out_t          res_item_o,
  input  logic          res_full_i
);

  localparam int unsigned PW = $clog2(NUM_PAGES);
  localparam int unsigned CW = RW;
  localparam int unsigned TW = CW + TOP_ORDER;

  bst_e             st_q, st_d;
  logic [10:0]      managed_q;
  logic [RW-1:0]    region;
  logic [RW-1:0]    idx_q, idx_d, np_q, np_d, left_q, left_d, step;
  logic [PW-1:0]    p_q, p_d, chk_a_q, chk_a_d;
  logic [ORD_W-1:0] cur_q, cur_d, want_q, want_d, cur_m1, co;
  logic             chk_v_q, chk_v_d;
  logic             status_q, status_d;
  logic [9:0]       blk_q, blk_d;
  logic [CW-1:0]    cnt_q [TOP_ORDER+1];
  logic [CW-1:0]    cnt_d [TOP_ORDER+1];
  logic [TW-1:0]    tot;
  logic [10:0]      fr_total;

  logic             ram_we;
  logic [PW-1:0]    ram_waddr, ram_raddr;
  ent_t             ram_wdata, rd;
  logic [$bits(ent_t)-1:0] ram_rdata;

  logic             inc_en, dec_en, clr;
  logic [ORD_W-1:0] inc_o, dec_o;
  logic [ORD_W-1:0] pk_from, pk_o;
  logic             pk_found;
  logic [31:0]      a32, b32;

  // region in use
  assign region   = (32'(managed_q) > NUM_PAGES) ? RW'(NUM_PAGES) : RW'(managed_q);
  assign region_o = region;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      managed_q <= 11'd1024;
    end else if (cfg_we_i) begin
      managed_q <= cfg_wdata_i;
    end
  end

  // block table
  bpa_ram #(
    .WIDTH($bits(ent_t)),
    .DEPTH(NUM_PAGES)
  ) u_tbl (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign rd = ent_t'(ram_rdata);

  // free total over all orders
  always_comb begin
    tot = '0;
    for (int o = 0; o <= TOP_ORDER; o++) begin
      tot = tot + (TW'(cnt_q[o]) << o);
    end
  end

  assign fr_total = (32'(tot) > 32'(FREE_SAT)) ? FREE_SAT : 11'(tot);

  // largest carve block that fits what is left
  always_comb begin
    co = '0;
    for (int o = 0; o <= TOP_ORDER; o++) begin
      if ((32'(1) << o) <= 32'(left_q)) begin
        co = ORD_W'(o);
      end
    end
  end

  assign step = RW'(32'(1) << co);

  // smallest non-empty order at or above pk_from
  assign pk_from = (st_q == B_IDLE) ? cmd_i.ord : cur_q + 1'b1;

  always_comb begin
    pk_found = 1'b0;
    pk_o     = '0;
    for (int o = TOP_ORDER; o >= 0; o--) begin
      if (ORD_W'(o) >= pk_from && cnt_q[o] != '0) begin
        pk_found = 1'b1;
        pk_o     = ORD_W'(o);
      end
    end
  end

  assign cur_m1 = cur_q - 1'b1;
  assign a32    = 32'(p_q) + (32'(1) << cur_m1);
  assign b32    = 32'(p_q) ^ (32'(1) << cur_q);

  // sequencer
  always_comb begin
    st_d      = st_q;
    idx_d     = idx_q;
    np_d      = np_q;
    left_d    = left_q;
    p_d       = p_q;
    cur_d     = cur_q;
    want_d    = want_q;
    chk_v_d   = chk_v_q;
    chk_a_d   = chk_a_q;
    status_d  = status_q;
    blk_d     = blk_q;
    ram_we    = 1'b0;
    ram_waddr = p_q;
    ram_wdata = '0;
    ram_raddr = p_q;
    inc_en    = 1'b0;
    inc_o     = cur_q;
    dec_en    = 1'b0;
    dec_o     = cur_q;
    clr       = 1'b0;
    cmd_pop_o = 1'b0;
    res_push_o = 1'b0;
    unique case (st_q)
      B_CINIT: begin
        clr    = 1'b1;
        idx_d  = '0;
        np_d   = '0;
        left_d = region;
        st_d   = B_CARVE;
      end
      B_CARVE: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q[PW-1:0];
        if (left_q != '0 && idx_q == np_q) begin
          ram_wdata = '{head: 1'b1, ord: co};
          inc_en    = 1'b1;
          inc_o     = co;
          np_d      = np_q + step;
          left_d    = left_q - step;
        end
        idx_d = idx_q + 1'b1;
        if (32'(idx_q) == NUM_PAGES - 1) begin
          st_d = B_IDLE;
        end
      end
      B_IDLE: begin
        if (cmd_valid_i && !res_full_i) begin
          cmd_pop_o = 1'b1;
          status_d  = STAT_OK;
          blk_d     = '0;
          want_d    = cmd_i.ord;
          cur_d     = cmd_i.ord;
          unique case (cmd_i.cls)
            CMD_ALLOC: begin
              status_d = STAT_FAIL;
              if (32'(cmd_i.page_count) <= 32'(tot) && pk_found) begin
                cur_d   = pk_o;
                idx_d   = '0;
                chk_v_d = 1'b0;
                st_d    = B_SRCH;
              end else begin
                st_d = B_DONE;
              end
            end
            CMD_FREE: begin
              p_d  = PW'(cmd_i.base_page);
              st_d = B_FRD;
            end
            CMD_FAIL: begin
              status_d = STAT_FAIL;
              st_d     = B_DONE;
            end
            default: begin
              st_d = B_DONE;
            end
          endcase
        end
      end
      B_SRCH: begin
        // one table read issued per cycle, checked the cycle after
        ram_raddr = idx_q[PW-1:0];
        if (chk_v_q && rd.head && rd.ord == cur_q) begin
          p_d       = chk_a_q;
          ram_we    = 1'b1;
          ram_waddr = chk_a_q;
          dec_en    = 1'b1;
          dec_o     = cur_q;
          status_d  = STAT_OK;
          blk_d     = 10'(chk_a_q);
          chk_v_d   = 1'b0;
          st_d      = (cur_q > want_q) ? B_SPL : B_DONE;
        end else if (idx_q < region) begin
          chk_v_d = 1'b1;
          chk_a_d = idx_q[PW-1:0];
          idx_d   = idx_q + 1'b1;
        end else begin
          chk_v_d = 1'b0;
          idx_d   = '0;
          if (pk_found) begin
            cur_d = pk_o;
          end else begin
            st_d = B_DONE;
          end
        end
      end
      B_SPL: begin
        cur_d = cur_m1;
        if (a32 < NUM_PAGES) begin
          ram_raddr = PW'(a32);
          chk_a_d   = PW'(a32);
          st_d      = B_SPL_WR;
        end else begin
          st_d = (cur_m1 > want_q) ? B_SPL : B_DONE;
        end
      end
      B_SPL_WR: begin
        ram_we    = 1'b1;
        ram_waddr = chk_a_q;
        ram_wdata = '{head: 1'b1, ord: cur_q};
        dec_en    = rd.head;
        dec_o     = rd.ord;
        inc_en    = 1'b1;
        inc_o     = cur_q;
        st_d      = (cur_q > want_q) ? B_SPL : B_DONE;
      end
      B_FRD: begin
        ram_raddr = p_q;
        st_d      = B_FWR;
      end
      B_FWR: begin
        ram_we    = 1'b1;
        ram_waddr = p_q;
        dec_en    = rd.head;
        dec_o     = rd.ord;
        st_d      = B_BRD;
      end
      B_BRD: begin
        if (cur_q == ORD_W'(TOP_ORDER) || b32 >= 32'(region)) begin
          st_d = B_PUT;
        end else begin
          ram_raddr = PW'(b32);
          chk_a_d   = PW'(b32);
          st_d      = B_BCHK;
        end
      end
      B_BCHK: begin
        if (rd.head && rd.ord == cur_q) begin
          ram_we    = 1'b1;
          ram_waddr = chk_a_q;
          dec_en    = 1'b1;
          dec_o     = cur_q;
          if (chk_a_q < p_q) begin
            p_d = chk_a_q;
          end
          cur_d = cur_q + 1'b1;
          st_d  = B_BRD;
        end else begin
          st_d = B_PUT;
        end
      end
      B_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = p_q;
        ram_wdata = '{head: 1'b1, ord: cur_q};
        inc_en    = 1'b1;
        inc_o     = cur_q;
        st_d      = B_DONE;
      end
      B_DONE: begin
        res_push_o = 1'b1;
        st_d       = B_IDLE;
      end
      default: begin
        st_d = B_CINIT;
      end
    endcase
    if (cfg_we_i) begin
      st_d = B_CINIT;
    end
  end

  assign res_item_o = '{status: status_q, block_page: blk_q, free_total: fr_total};

  // per-order free block counts
  always_comb begin
    for (int o = 0; o <= TOP_ORDER; o++) begin
      cnt_d[o] = cnt_q[o];
      if (clr) begin
        cnt_d[o] = '0;
      end else begin
        if (dec_en && dec_o == ORD_W'(o) && cnt_q[o] != '0) begin
          cnt_d[o] = cnt_d[o] - 1'b1;
        end
        if (inc_en && inc_o == ORD_W'(o)) begin
          cnt_d[o] = cnt_d[o] + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= B_CINIT;
      chk_v_q <= 1'b0;
      for (int o = 0; o <= TOP_ORDER; o++) begin
        cnt_q[o] <= '0;
      end
    end else begin
      st_q    <= st_d;
      chk_v_q <= chk_v_d;
      for (int o = 0; o <= TOP_ORDER; o++) begin
        cnt_q[o] <= cnt_d[o];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    np_q     <= np_d;
    left_q   <= left_d;
    p_q      <= p_d;
    cur_q    <= cur_d;
    want_q   <= want_d;
    chk_a_q  <= chk_a_d;
    status_q <= status_d;
    blk_q    <= blk_d;
  end

  a_carve_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == B_CARVE && st_d == B_IDLE) |=> (32'(tot) == 32'(region)))
    else $error("carved blocks do not cover the region");

  a_res_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !res_full_i)
    else $error("result pushed into a full queue");

  a_cfg_recarve: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> (st_q == B_CINIT))
    else $error("register write did not restart carving");

endmodule
